[hdl/cmag_pkg.sv]
package cmag_pkg;

    // Default sample width of the real and imaginary parts.
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
    } cmag_ctl_t;

endpackage

[hdl/cmag_isqrt.sv]
module cmag_isqrt
    import cmag_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      enable,
    input  cmag_ctl_t                 ctl_in,
    input  logic [2*SAMPLE_WIDTH-1:0] radicand,
    output cmag_ctl_t                 ctl_out,
    output logic [SAMPLE_WIDTH-1:0]   root
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int NW = 2 * SAMPLE_WIDTH;
    localparam int RW = SAMPLE_WIDTH + 2;

    // Stage k register holds the state after k+1 root bits are resolved.
    logic [NW-1:0] rad_reg  [W];
    logic [RW-1:0] rem_reg  [W];
    logic [W-1:0]  root_reg [W];
    cmag_ctl_t     ctl_reg  [W];

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_stage
            logic [NW-1:0] rad_prev;
            logic [RW-1:0] rem_prev;
            logic [W-1:0]  root_prev;
            cmag_ctl_t     ctl_prev;
            logic [RW-1:0] rem_shift;
            logic [RW-1:0] trial;
            logic          take;
            logic [NW-1:0] rad_next;
            logic [RW-1:0] rem_next;
            logic [W-1:0]  root_next;

            // The first stage starts from the radicand with an empty root.
            if (k == 0) begin : g_first
                assign rad_prev  = radicand;
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign ctl_prev  = ctl_in;
            end else begin : g_next
                assign rad_prev  = rad_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign ctl_prev  = ctl_reg[k-1];
            end

            // Bring down two radicand bits and try the next root bit.
            always_comb begin
                rem_shift = {rem_prev[RW-3:0], rad_prev[NW-1:NW-2]};
                trial     = {root_prev, 2'b01};
                take      = (rem_shift >= trial);
                rem_next  = take ? (rem_shift - trial) : rem_shift;
                root_next = {root_prev[W-2:0], take};
                rad_next  = {rad_prev[NW-3:0], 2'b00};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    ctl_reg[k] <= '0;
                end else if (enable) begin
                    ctl_reg[k] <= ctl_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (enable) begin
                    rad_reg[k]  <= rad_next;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end
        end
    endgenerate

    assign ctl_out = ctl_reg[W-1];
    assign root    = root_reg[W-1];

endmodule

[hdl/complex_magnitude_unit.sv]
// Complex magnitude unit.
// The slave channel takes one complex sample per item: tdata carries the
// signed real part in the low SAMPLE_WIDTH bits and the signed imaginary part
// above it; tuser[0] marks the last element of a vector. The master channel
// returns floor(sqrt(re*re + im*im)) as an unsigned value on the same scale
// in tdata, with the last flag copied to tuser[0].
// From acceptance to m_tvalid a sample passes the absolute-value register,
// the squares, the sum and the square-root pipeline, which resolves the root
// bits in order. Throughput is one item per cycle unless the receiver stalls;
// every stage holds one item. Reset clears all valid bits, so the pipeline
// comes up empty and s_tready is high. When the receiver stalls with a
// result waiting, the whole pipeline holds and s_tready drops in the same
// cycle; nothing is lost or repeated, and the flow resumes as soon as
// m_tready returns.
module complex_magnitude_unit
    import cmag_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // real_part [W-1:0], imag_part [2W-1:W], zero fill above
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
    // last_in [0]
    input  logic [0:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // magnitude [W-1:0], zero fill above
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata,
    // last_out [0]
    output logic [0:0]                           m_tuser
);

    localparam int W     = SAMPLE_WIDTH;
    localparam int OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    logic            enable;
    cmag_ctl_t       ctl_in;
    cmag_ctl_t       ctl_abs_reg, ctl_sq_reg, ctl_sum_reg, ctl_out;
    logic [W-1:0]    re_raw, im_raw;
    logic [W-1:0]    re_abs_next, im_abs_next;
    logic [W-1:0]    re_abs_reg, im_abs_reg;
    logic [2*W-1:0]  re_sq_reg, im_sq_reg;
    logic [2*W-1:0]  sum_reg;
    logic [W-1:0]    root;

    // The pipeline advances whenever the output register is free or drained.
    assign enable   = !ctl_out.valid || m_tready;
    assign s_tready = enable;

    assign re_raw       = s_tdata[W-1:0];
    assign im_raw       = s_tdata[2*W-1:W];
    assign ctl_in.valid = s_tvalid;
    assign ctl_in.last  = s_tuser[0];

    // Absolute values; the most negative code maps to 2^(W-1) unsigned.
    always_comb begin
        re_abs_next = re_raw[W-1] ? (~re_raw + W'(1)) : re_raw;
        im_abs_next = im_raw[W-1] ? (~im_raw + W'(1)) : im_raw;
    end

    // Control bits of the front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_abs_reg <= '0;
            ctl_sq_reg  <= '0;
            ctl_sum_reg <= '0;
        end else if (enable) begin
            ctl_abs_reg <= ctl_in;
            ctl_sq_reg  <= ctl_abs_reg;
            ctl_sum_reg <= ctl_sq_reg;
        end
    end

    // Front datapath: absolute value, squares, sum of squares.
    always_ff @(posedge aclk) begin
        if (enable) begin
            re_abs_reg <= re_abs_next;
            im_abs_reg <= im_abs_next;
            re_sq_reg  <= (2*W)'(re_abs_reg) * (2*W)'(re_abs_reg);
            im_sq_reg  <= (2*W)'(im_abs_reg) * (2*W)'(im_abs_reg);
            sum_reg    <= re_sq_reg + im_sq_reg;
        end
    end

    // One root bit per stage; the last stage is the output register.
    cmag_isqrt #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .enable  (enable),
        .ctl_in  (ctl_sum_reg),
        .radicand(sum_reg),
        .ctl_out (ctl_out),
        .root    (root)
    );

    assign m_tvalid   = ctl_out.valid;
    assign m_tdata    = OUT_W'(root);
    assign m_tuser[0] = ctl_out.last;

endmodule

[hdl/cmag_checker.sv]
module cmag_checker
    import cmag_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
    input logic [0:0]                           s_tuser,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata,
    input logic [0:0]                           m_tuser
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed or vanished");

    // The input side stalls exactly when a result waits untaken.
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // The magnitude never reaches three quarters of full scale.
    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[SAMPLE_WIDTH-1:SAMPLE_WIDTH-2] != 2'b11)
        else $error("magnitude out of range");

endmodule

bind complex_magnitude_unit cmag_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_cmag_checker (.*);

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import cmag_pkg::*;

    localparam int W    = SAMPLE_WIDTH_DEF;
    localparam int TD_W = ((2*W+7)/8)*8;
    localparam int MD_W = ((W+7)/8)*8;

    // One complex sample waiting to be sent, with the idle cycles that precede it.
    typedef struct {
        logic signed [W-1:0] re_part;
        logic signed [W-1:0] im_part;
        logic                last;
        int unsigned         gap;
        bit                  wait_for_drain;
    } sample_item_t;

    // One magnitude the block owes us.
    typedef struct {
        logic [W-1:0] magnitude;
        logic         last;
    } mag_result_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [TD_W-1:0]   s_tdata = '0;
    logic [0:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [MD_W-1:0]   m_tdata;
    logic [0:0]        m_tuser;

    sample_item_t samples_to_send[$];
    mag_result_t  expected_mags[$];

    sample_item_t head_item;
    mag_result_t  sent_mag;
    mag_result_t  want;
    int unsigned  gap_left = 0;
    bit           gap_armed = 1'b0;
    int unsigned  stall_left = 0;
    logic         rx_hold = 1'b0;
    int unsigned  accepted_count = 0;
    int unsigned  result_count = 0;
    int unsigned  vector_end_count = 0;
    int unsigned  error_count = 0;

    complex_magnitude_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 0;
    end

    // Floor of the root of re^2 + im^2, found one root bit at a time from the top.
    function automatic logic [W-1:0] predict_magnitude(input logic [W-1:0] re_raw,
                                                       input logic [W-1:0] im_raw);
        longint unsigned re_abs;
        longint unsigned im_abs;
        longint unsigned sum_sq;
        longint unsigned root;
        longint unsigned trial;
        re_abs = re_raw[W-1] ? (longint'(1) << W) - longint'(re_raw) : longint'(re_raw);
        im_abs = im_raw[W-1] ? (longint'(1) << W) - longint'(im_raw) : longint'(im_raw);
        sum_sq = re_abs * re_abs + im_abs * im_abs;
        root = 0;
        for (int b = W; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sum_sq)
                root = trial;
        end
        return root[W-1:0];
    endfunction

    // A random part: mostly full-range values, with zeros, extremes and small values mixed in.
    function automatic logic signed [W-1:0] pick_part();
        logic signed [W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: begin
                case ($urandom_range(0, 3))
                    0: v = {1'b0, {(W-1){1'b1}}};
                    1: v = {1'b1, {(W-1){1'b0}}};
                    2: v = W'(1);
                    default: v = '1;
                endcase
            end
            2, 3: v = W'($signed($urandom_range(0, 63)) - 32);
            default: v = W'($urandom);
        endcase
        return v;
    endfunction

    task automatic add_sample(input logic signed [W-1:0] re_part,
                              input logic signed [W-1:0] im_part,
                              input logic last, input int unsigned gap,
                              input bit wait_for_drain);
        sample_item_t it;
        it.re_part = re_part;
        it.im_part = im_part;
        it.last = last;
        it.gap = gap;
        it.wait_for_drain = wait_for_drain;
        samples_to_send.push_back(it);
    endtask

    // Sender: records each accepted item's expected magnitude and offers the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            gap_left = 0;
            gap_armed = 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sent_mag.magnitude = predict_magnitude(s_tdata[W-1:0], s_tdata[2*W-1:W]);
                sent_mag.last = s_tuser[0];
                expected_mags.push_back(sent_mag);
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (samples_to_send.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    if (!gap_armed) begin
                        gap_left = samples_to_send[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left > 0) begin
                        gap_left--;
                        s_tvalid <= 1'b0;
                    end else if (samples_to_send[0].wait_for_drain &&
                                 expected_mags.size() != 0) begin
                        s_tvalid <= 1'b0;
                    end else begin
                        head_item = samples_to_send.pop_front();
                        s_tdata <= TD_W'({head_item.im_part, head_item.re_part});
                        s_tuser <= head_item.last;
                        s_tvalid <= 1'b1;
                        gap_armed = 1'b0;
                    end
                end
            end
        end
    end

    // Receiver: checks each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_mags.size() == 0) begin
                    $error("result with no item outstanding: magnitude %0d", m_tdata);
                    error_count++;
                end else begin
                    want = expected_mags.pop_front();
                    if (m_tdata !== MD_W'(want.magnitude)) begin
                        $error("magnitude mismatch: expected %0d, actual %0d",
                               want.magnitude, m_tdata);
                        error_count++;
                    end
                    if (m_tuser[0] !== want.last) begin
                        $error("last_out mismatch: expected %0b, actual %0b",
                               want.last, m_tuser[0]);
                        error_count++;
                    end
                end
                result_count++;
                if (m_tuser[0] === 1'b1)
                    vector_end_count++;
                // The stall pattern changes every 128 results.
                case ((result_count / 128) % 3)
                    0: stall_left = 0;
                    1: stall_left = $urandom_range(0, 14);
                    default: stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14) : 0;
                endcase
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long output hold once traffic is flowing, so the pipeline fills and stalls its input.
    initial begin
        while (accepted_count < 400)
            @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Reset, stimulus and end of run.
    initial begin
        int unsigned pace;
        int unsigned gap;

        // Directed samples: extremes, missing parts, signs and small exact cases.
        add_sample(16'sd0, 16'sd0, 1'b0, 0, 1'b0);
        add_sample(16'sd32767, 16'sd0, 1'b0, 0, 1'b0);
        add_sample(-16'sd32768, 16'sd0, 1'b0, 0, 1'b0);
        add_sample(16'sd0, 16'sd32767, 1'b0, 0, 1'b0);
        add_sample(16'sd0, -16'sd32768, 1'b1, 0, 1'b0);
        add_sample(-16'sd32768, -16'sd32768, 1'b0, 3, 1'b0);
        add_sample(16'sd32767, 16'sd32767, 1'b0, 0, 1'b0);
        add_sample(-16'sd32768, 16'sd32767, 1'b0, 1, 1'b0);
        add_sample(16'sd32767, -16'sd32768, 1'b1, 0, 1'b0);
        add_sample(16'sd1, 16'sd0, 1'b0, 0, 1'b0);
        add_sample(-16'sd1, 16'sd0, 1'b0, 0, 1'b0);
        add_sample(16'sd0, -16'sd1, 1'b0, 2, 1'b0);
        add_sample(-16'sd1, -16'sd1, 1'b0, 0, 1'b0);
        add_sample(16'sd1, 16'sd1, 1'b1, 0, 1'b0);
        add_sample(16'sd3, 16'sd4, 1'b0, 0, 1'b0);
        add_sample(-16'sd3, -16'sd4, 1'b0, 0, 1'b0);
        add_sample(16'sd3, -16'sd5, 1'b0, 14, 1'b0);
        add_sample(-16'sd12000, 16'sd16000, 1'b0, 0, 1'b0);
        add_sample(16'sd23170, 16'sd23170, 1'b0, 0, 1'b0);
        add_sample(16'sd23171, -16'sd23171, 1'b0, 0, 1'b0);
        add_sample(-16'sd21846, 16'sd21845, 1'b1, 0, 1'b0);

        // Random samples in chunks, each chunk with its own sender pace.
        for (int i = 0; i < 1430; i++) begin
            pace = (i / 60) % 3;
            case (pace)
                0: gap = 0;
                1: gap = $urandom_range(0, 14);
                default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14) : 0;
            endcase
            add_sample(pick_part(), pick_part(), ($urandom_range(0, 7) == 0), gap,
                       (i == 0 || i == 700 || i == 1100));
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (samples_to_send.size() != 0 || s_tvalid || expected_mags.size() != 0)
            @(posedge aclk);
        // Let any stray result surface after the last expected one.
        repeat (40) @(posedge aclk);

        $display("Run covered %0d items and %0d results (%0d vector ends): extremes,",
                 accepted_count, result_count, vector_end_count);
        $display("missing parts and random samples under input gaps and output stalls.");
        if (error_count == 0 && expected_mags.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
